/* rtl/hilb_pkg.sv */
`default_nettype none

package hilb_pkg;

	// table depth
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// fixed field widths
	localparam int ENTRY_W = 4;
	localparam int CONN_W = 16;
	localparam int LAT_W = 24;
	localparam int WORD_W = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [WORD_W-1:0] LFSR_MASK = 32'hA300_0000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b1;

	// item kinds
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	typedef enum logic [2:0] {
		STRAT_ROUND_ROBIN = 3'd0,
		STRAT_LEAST_CONN = 3'd1,
		STRAT_RANDOM = 3'd2,
		STRAT_LEAST_LAT = 3'd3,
		STRAT_HASH = 3'd4
	} strategy_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_DIV,
		ST_RANK,
		ST_DONE
	} state_t;

	// one step of the galois lfsr
	function automatic logic [WORD_W-1:0] lfsr_next(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_MASK;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

/* rtl/hilb_if.sv */
`default_nettype none

interface hilb_req_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [hilb_pkg::ENTRY_W-1:0] entry_index;
	logic healthy_flag;
	logic [hilb_pkg::CONN_W-1:0] connection_count;
	logic [hilb_pkg::LAT_W-1:0] latency_us;
	logic [hilb_pkg::WORD_W-1:0] client_hash;
	logic hash_present;

	modport source (
		output valid, opcode, entry_index, healthy_flag, connection_count,
			latency_us, client_hash, hash_present,
		input ready
	);
	modport sink (
		input valid, opcode, entry_index, healthy_flag, connection_count,
			latency_us, client_hash, hash_present,
		output ready
	);
endinterface

interface hilb_resp_if;
	logic valid;
	logic ready;
	logic found;
	logic [hilb_pkg::ENTRY_W-1:0] chosen_index;

	modport source (
		output valid, found, chosen_index,
		input ready
	);
	modport sink (
		input valid, found, chosen_index,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/healthy_instance_load_balancer_core.sv */
`default_nettype none

// healthy instance load balancer: keeps a table of TABLE_DEPTH entries
// (healthy flag, connection count, latency in us). an update beat writes
// one entry and gives no result; a select beat gives one result beat
// naming a healthy entry, or found = 0 when none is healthy. a select
// walks the table one entry a cycle, as the entry store has a single
// read port; the least-connections and least-latency strategies then
// finish at once, the others run a shared restoring divider one quotient
// bit a cycle for the rank and walk the healthy flags again to find the
// entry of that rank. req is not ready while a select is at work. the
// result sits in an output register, so updates are still taken while it
// waits. writing random_seed reloads the lfsr at once (zero loads as one).
module healthy_instance_load_balancer_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [hilb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hilb_pkg::WORD_W-1:0] cfg_data,
	hilb_req_if.sink req,
	hilb_resp_if.source resp
);

	localparam int IDX_W = hilb_pkg::IDX_W;
	localparam int CNT_W = hilb_pkg::CNT_W;
	localparam int WORD_W = hilb_pkg::WORD_W;
	localparam int LAT_W = hilb_pkg::LAT_W;
	localparam int CONN_W = hilb_pkg::CONN_W;
	localparam int NUM = hilb_pkg::TABLE_DEPTH;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM - 1);
	localparam int STEP_W = $clog2(WORD_W);

	// fsm
	hilb_pkg::state_t state_q, state_nxt;

	// configuration
	hilb_pkg::strategy_t strategy_q;
	logic [WORD_W-1:0] lfsr_q;
	logic [WORD_W-1:0] rot_q;

	// entry store: healthy flags in flops, the rest in memory
	logic [NUM-1:0] healthy_q;
	logic [CONN_W-1:0] conn_mem [NUM];
	logic [LAT_W-1:0] lat_mem [NUM];

	// walk control
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] seen_q;
	logic have_q;
	logic [LAT_W-1:0] best_q;
	logic [IDX_W-1:0] best_idx_q;

	// read stage of the walk
	logic vld_s1;
	logic hlt_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [LAT_W-1:0] key_s1;

	// divider
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] dividend_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W:0] trial;
	logic trial_ge;

	// captured select fields
	logic [WORD_W-1:0] hash_q;
	logic hash_present_q;

	// result
	logic found_q;
	logic [IDX_W-1:0] chosen_q;
	logic out_valid_q;
	logic out_found_q;
	logic [hilb_pkg::ENTRY_W-1:0] out_index_q;

	logic req_fire;
	logic upd_ok;
	logic rank_hit;
	logic out_load;
	logic [WORD_W-1:0] lfsr_step;
	logic [IDX_W-1:0] wr_addr;

	assign req_fire = req.valid && req.ready;
	assign upd_ok = (32'(req.entry_index) < 32'(NUM));
	assign wr_addr = IDX_W'(req.entry_index);
	assign trial = {rem_q, dividend_q[WORD_W-1]};
	assign trial_ge = (trial >= {1'b0, cnt_q});
	assign rank_hit = healthy_q[idx_q] && (seen_q == rem_q);
	assign lfsr_step = hilb_pkg::lfsr_next(lfsr_q);
	assign out_load = (state_q == hilb_pkg::ST_DONE) && (!out_valid_q || resp.ready);

	assign resp.valid = out_valid_q;
	assign resp.found = out_found_q;
	assign resp.chosen_index = out_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hilb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		req.ready = 1'b0;
		case (state_q)
			hilb_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && req.opcode == hilb_pkg::OP_SELECT) begin
					state_nxt = hilb_pkg::ST_SCAN;
				end
			end
			hilb_pkg::ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_nxt = hilb_pkg::ST_SCAN_END;
				end
			end
			hilb_pkg::ST_SCAN_END: state_nxt = hilb_pkg::ST_DECIDE;
			hilb_pkg::ST_DECIDE: begin
				if (cnt_q == '0) begin
					state_nxt = hilb_pkg::ST_DONE;
				end else begin
					case (strategy_q)
						hilb_pkg::STRAT_LEAST_CONN,
						hilb_pkg::STRAT_LEAST_LAT: state_nxt = hilb_pkg::ST_DONE;
						default: state_nxt = hilb_pkg::ST_DIV;
					endcase
				end
			end
			hilb_pkg::ST_DIV: begin
				if (step_q == '0) begin
					state_nxt = hilb_pkg::ST_RANK;
				end
			end
			hilb_pkg::ST_RANK: begin
				if (rank_hit) begin
					state_nxt = hilb_pkg::ST_DONE;
				end
			end
			hilb_pkg::ST_DONE: begin
				if (out_load) begin
					state_nxt = hilb_pkg::ST_IDLE;
				end
			end
			default: state_nxt = hilb_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= hilb_pkg::STRAT_ROUND_ROBIN;
			lfsr_q <= WORD_W'(1);
			rot_q <= '0;
			healthy_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			seen_q <= '0;
			have_q <= 1'b0;
			step_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == hilb_pkg::ST_SCAN);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end

			// the user must write config only while the block is idle; the block does not enforce it
			if (cfg_we) begin
				case (cfg_index)
					hilb_pkg::CFG_STRATEGY: strategy_q <= hilb_pkg::strategy_t'(cfg_data[2:0]);
					hilb_pkg::CFG_SEED: lfsr_q <= (cfg_data == '0) ? WORD_W'(1) : cfg_data;
					default: ;
				endcase
			end

			// walk stage: count healthy entries and keep the running minimum
			if (vld_s1 && hlt_s1) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (!have_q || key_s1 < best_q) begin
					have_q <= 1'b1;
				end
			end

			case (state_q)
				hilb_pkg::ST_IDLE: begin
					if (req_fire) begin
						if (req.opcode == hilb_pkg::OP_UPDATE) begin
							if (upd_ok) begin
								healthy_q[wr_addr] <= req.healthy_flag;
							end
						end else begin
							idx_q <= '0;
							cnt_q <= '0;
							have_q <= 1'b0;
						end
					end
				end
				hilb_pkg::ST_SCAN: idx_q <= idx_q + IDX_W'(1);
				hilb_pkg::ST_DECIDE: begin
					idx_q <= '0;
					seen_q <= '0;
					step_q <= STEP_W'(WORD_W - 1);
					if (cnt_q != '0) begin
						case (strategy_q)
							hilb_pkg::STRAT_ROUND_ROBIN: rot_q <= rot_q + WORD_W'(1);
							hilb_pkg::STRAT_RANDOM: lfsr_q <= lfsr_step;
							default: ;
						endcase
					end
				end
				hilb_pkg::ST_DIV: step_q <= step_q - STEP_W'(1);
				hilb_pkg::ST_RANK: begin
					if (!rank_hit) begin
						idx_q <= idx_q + IDX_W'(1);
						if (healthy_q[idx_q]) begin
							seen_q <= seen_q + CNT_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// entry store and datapath
	always_ff @(posedge clk) begin
		if (state_q == hilb_pkg::ST_IDLE && req_fire && req.opcode == hilb_pkg::OP_UPDATE
				&& upd_ok) begin
			conn_mem[wr_addr] <= req.connection_count;
			lat_mem[wr_addr] <= req.latency_us;
		end

		// registered read of the walked entry
		hlt_s1 <= healthy_q[idx_q];
		idx_s1 <= idx_q;
		if (strategy_q == hilb_pkg::STRAT_LEAST_CONN) begin
			key_s1 <= LAT_W'(conn_mem[idx_q]);
		end else begin
			key_s1 <= lat_mem[idx_q];
		end

		// strict less-than keeps ties on the lowest index
		if (vld_s1 && hlt_s1 && (!have_q || key_s1 < best_q)) begin
			best_q <= key_s1;
			best_idx_q <= idx_s1;
		end

		if (state_q == hilb_pkg::ST_IDLE && req_fire) begin
			hash_q <= req.client_hash;
			hash_present_q <= req.hash_present;
		end

		case (state_q)
			hilb_pkg::ST_DECIDE: begin
				rem_q <= '0;
				found_q <= (cnt_q != '0);
				// minimum strategies take the walk's winner, the rest start from zero
				chosen_q <= ((cnt_q != '0) && (strategy_q inside {hilb_pkg::STRAT_LEAST_CONN,
						hilb_pkg::STRAT_LEAST_LAT})) ? best_idx_q : '0;
				case (strategy_q)
					hilb_pkg::STRAT_ROUND_ROBIN: dividend_q <= rot_q;
					hilb_pkg::STRAT_RANDOM: dividend_q <= lfsr_step;
					hilb_pkg::STRAT_HASH: dividend_q <= hash_present_q ? hash_q : '0;
					default: dividend_q <= '0;
				endcase
			end
			hilb_pkg::ST_DIV: begin
				// restoring step, remainder only
				dividend_q <= {dividend_q[WORD_W-2:0], 1'b0};
				if (trial_ge) begin
					rem_q <= CNT_W'(trial - {1'b0, cnt_q});
				end else begin
					rem_q <= trial[CNT_W-1:0];
				end
			end
			hilb_pkg::ST_RANK: begin
				if (rank_hit) begin
					chosen_q <= idx_q;
				end
			end
			default: ;
		endcase

		if (out_load) begin
			out_found_q <= found_q;
			out_index_q <= hilb_pkg::ENTRY_W'(chosen_q);
		end
	end

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
	import hilb_pkg::*;

	// spare strategy codes, both fall back to the first healthy entry
	localparam logic [2:0] STRAT_SPARE_LO = 3'd5;
	localparam logic [2:0] STRAT_SPARE_HI = 3'd7;

	// settling wait, long enough for a select still at work to finish
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 48;
	// long hold-off on the result side, enough to fill the block and stall req
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 12;
	localparam int BEATS_PER_PHASE = 75;
	localparam int DIR_ROWS = 34;

	typedef struct packed {
		logic opcode;
		logic [ENTRY_W-1:0] entry_index;
		logic healthy_flag;
		logic [CONN_W-1:0] connection_count;
		logic [LAT_W-1:0] latency_us;
		logic [WORD_W-1:0] client_hash;
		logic hash_present;
	} lb_req_t;

	typedef struct packed {
		logic found;
		logic [ENTRY_W-1:0] chosen_index;
	} lb_pick_t;

	typedef enum logic [1:0] {
		ROW_BEAT,
		ROW_SET_STRATEGY,
		ROW_SET_SEED
	} row_kind_t;

	// one row of the directed plan; word is the client hash of a beat row,
	// or the register value of a register row
	typedef struct packed {
		row_kind_t kind;
		logic opcode;
		logic [ENTRY_W-1:0] entry_index;
		logic healthy_flag;
		logic [CONN_W-1:0] connection_count;
		logic [LAT_W-1:0] latency_us;
		logic [WORD_W-1:0] word;
		logic hash_present;
		logic pinned;
		logic want_found;
		logic [ENTRY_W-1:0] want_index;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0] cfg_data;

	hilb_req_if req_bus ();
	hilb_resp_if resp_bus ();

	healthy_instance_load_balancer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_bus),
		.resp(resp_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: our own copy of the instance table and pick state
	logic tbl_healthy [TABLE_DEPTH];
	logic [CONN_W-1:0] tbl_conn [TABLE_DEPTH];
	logic [LAT_W-1:0] tbl_lat [TABLE_DEPTH];
	logic [2:0] cur_strategy;
	logic [WORD_W-1:0] rr_counter;
	logic [WORD_W-1:0] rng_state;

	// picks still owed by the block, oldest first
	lb_pick_t picks_due [$];
	int unsigned mismatches = 0;

	// idling controls shared by both sides
	bit gaps_on = 1'b1;
	bit hold_pending = 1'b0;

	// directed plan, walked in order after reset
	plan_row_t directed_plan [DIR_ROWS] = '{
		// nothing is healthy straight after reset
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b1, 1'b0, 4'd0},
		// top entry with every field at its maximum, hash fields ignored here
		'{ROW_BEAT, OP_UPDATE, 4'd15, 1'b1, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			1'b0, 1'b0, 4'd0},
		// bottom entry with everything at zero
		'{ROW_BEAT, OP_UPDATE, 4'd0, 1'b1, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		// an entry that stays unhealthy
		'{ROW_BEAT, OP_UPDATE, 4'd7, 1'b0, 16'h5, 24'h5, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		// round robin: rank 0, update fields on a select are ignored
		'{ROW_BEAT, OP_SELECT, 4'd9, 1'b1, 16'hFFFF, 24'hFF_FFFF, 32'h0, 1'b0,
			1'b1, 1'b1, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b1, 1'b1, 4'd15},
		// rotation wraps back
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_SET_STRATEGY, OP_UPDATE, 4'd0, 1'b0, 16'h0, 24'h0, 32'(STRAT_LEAST_CONN),
			1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b1, 1'b1, 4'd0},
		// tie on zero connections goes to the lower index
		'{ROW_BEAT, OP_UPDATE, 4'd3, 1'b1, 16'h0, 24'h10, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b1, 1'b1, 4'd0},
		'{ROW_BEAT, OP_UPDATE, 4'd0, 1'b1, 16'h2, 24'h20, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_SET_STRATEGY, OP_UPDATE, 4'd0, 1'b0, 16'h0, 24'h0, 32'(STRAT_LEAST_LAT),
			1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_SET_STRATEGY, OP_UPDATE, 4'd0, 1'b0, 16'h0, 24'h0, 32'(STRAT_RANDOM),
			1'b0, 1'b0, 1'b0, 4'd0},
		// zero seed loads the lfsr with one
		'{ROW_SET_SEED, OP_UPDATE, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_SET_SEED, OP_UPDATE, 4'd0, 1'b0, 16'h0, 24'h0, 32'hFFFF_FFFF, 1'b0,
			1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_SET_STRATEGY, OP_UPDATE, 4'd0, 1'b0, 16'h0, 24'h0, 32'(STRAT_HASH),
			1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'hFFFF_FFFF, 1'b1,
			1'b0, 1'b0, 4'd0},
		// absent client hash takes the first healthy entry
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'hFFFF_FFFF, 1'b0,
			1'b1, 1'b1, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b1, 1'b1, 1'b1, 4'd0},
		// unused strategy codes fall back to the first healthy entry
		'{ROW_SET_STRATEGY, OP_UPDATE, 4'd0, 1'b0, 16'h0, 24'h0, 32'(STRAT_SPARE_HI),
			1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b1, 1'b1, 4'd0},
		'{ROW_SET_STRATEGY, OP_UPDATE, 4'd0, 1'b0, 16'h0, 24'h0, 32'(STRAT_SPARE_LO),
			1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_UPDATE, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b1, 1'b1, 4'd3},
		// empty the table again: no healthy entry gives found low, index zero
		'{ROW_BEAT, OP_UPDATE, 4'd3, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_UPDATE, 4'd15, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'd0},
		'{ROW_BEAT, OP_SELECT, 4'd0, 1'b0, 16'h0, 24'h0, 32'h0, 1'b0, 1'b1, 1'b0, 4'd0},
		'{ROW_SET_STRATEGY, OP_UPDATE, 4'd0, 1'b0, 16'h0, 24'h0, 32'(STRAT_ROUND_ROBIN),
			1'b0, 1'b0, 1'b0, 4'd0}
	};

	// ---------------------------------------------------------------- predictor

	function automatic void clear_predictor();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_healthy[i] = 1'b0;
			tbl_conn[i] = '0;
			tbl_lat[i] = '0;
		end
		cur_strategy = STRAT_ROUND_ROBIN;
		rr_counter = '0;
		rng_state = 32'd1;
	endfunction

	// galois step: shift right, fold the mask back in when a one drops out
	function automatic logic [WORD_W-1:0] lfsr_step(input logic [WORD_W-1:0] v);
		return {1'b0, v[WORD_W-1:1]} ^ (v[0] ? LFSR_MASK : '0);
	endfunction

	function automatic int unsigned healthy_total();
		int unsigned n;
		n = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (tbl_healthy[i]) begin
				n++;
			end
		end
		return n;
	endfunction

	// table index of the healthy entry holding a given rank
	function automatic logic [ENTRY_W-1:0] entry_at_rank(input int unsigned rank);
		int unsigned seen;
		seen = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (tbl_healthy[i]) begin
				if (seen == rank) begin
					return ENTRY_W'(i);
				end
				seen++;
			end
		end
		return '0;
	endfunction

	function automatic void apply_update(input lb_req_t b);
		tbl_healthy[b.entry_index] = b.healthy_flag;
		tbl_conn[b.entry_index] = b.connection_count;
		tbl_lat[b.entry_index] = b.latency_us;
	endfunction

	function automatic lb_pick_t pick_instance(input lb_req_t b);
		lb_pick_t r;
		int unsigned total;
		logic [WORD_W-1:0] best;
		logic [WORD_W-1:0] metric;
		r = '0;
		total = healthy_total();
		// nothing healthy: counter and lfsr stay put
		if (total == 0) begin
			return r;
		end
		r.found = 1'b1;
		case (cur_strategy)
			STRAT_ROUND_ROBIN: begin
				r.chosen_index = entry_at_rank(rr_counter % total);
				rr_counter++;
			end
			STRAT_LEAST_CONN, STRAT_LEAST_LAT: begin
				best = '1;
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (tbl_healthy[i]) begin
						metric = (cur_strategy == STRAT_LEAST_CONN) ?
							WORD_W'(tbl_conn[i]) : WORD_W'(tbl_lat[i]);
						// strict compare keeps ties on the lowest index
						if (metric < best) begin
							best = metric;
							r.chosen_index = ENTRY_W'(i);
						end
					end
				end
			end
			STRAT_RANDOM: begin
				rng_state = lfsr_step(rng_state);
				r.chosen_index = entry_at_rank(rng_state % total);
			end
			STRAT_HASH: begin
				r.chosen_index = entry_at_rank(b.hash_present ? b.client_hash % total : 0);
			end
			default: begin
				r.chosen_index = entry_at_rank(0);
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- helpers

	function automatic int unsigned idle_draw();
		return gaps_on ? $urandom_range(0, 8) : 0;
	endfunction

	task automatic report_mismatch(input string what, input lb_pick_t got,
			input lb_pick_t want);
		mismatches++;
		$display("%0t mismatch, %s: got found=%0d index=%0d, want found=%0d index=%0d",
			$time, what, got.found, got.chosen_index, want.found, want.chosen_index);
	endtask

	// register write, only ever issued with the block idle; updates our copy too
	task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_sel,
			input logic [WORD_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= reg_sel;
		cfg_data <= data;
		@(posedge clk);
		if (reg_sel == CFG_STRATEGY) begin
			cur_strategy = data[2:0];
		end else begin
			// zero seed would lock the lfsr, so it loads as one
			rng_state = (data == '0) ? 32'd1 : data;
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// sender pauses until every owed pick is back, then lets the block drain
	task automatic settle_block();
		req_bus.valid <= 1'b0;
		while (picks_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// offer one beat after a random gap; predict at the accepting edge
	task automatic send_beat(input lb_req_t b, input logic pinned, input lb_pick_t pinned_pick);
		int unsigned gap;
		lb_pick_t pick;
		gap = idle_draw();
		if (gap != 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.opcode <= b.opcode;
		req_bus.entry_index <= b.entry_index;
		req_bus.healthy_flag <= b.healthy_flag;
		req_bus.connection_count <= b.connection_count;
		req_bus.latency_us <= b.latency_us;
		req_bus.client_hash <= b.client_hash;
		req_bus.hash_present <= b.hash_present;
		do @(posedge clk); while (!(req_bus.valid && req_bus.ready));
		if (b.opcode == OP_UPDATE) begin
			apply_update(b);
		end else begin
			pick = pick_instance(b);
			// directed rows with a typed-in answer use it, the predictor still moves on
			if (pinned) begin
				pick = pinned_pick;
			end
			picks_due = {picks_due, pick};
		end
	endtask

	// random beat: close metric values give many ties, health bias sets occupancy
	function automatic lb_req_t random_beat(input int unsigned health_pct);
		lb_req_t b;
		b.opcode = ($urandom_range(0, 99) < 55) ? OP_SELECT : OP_UPDATE;
		b.entry_index = ENTRY_W'($urandom_range(0, TABLE_DEPTH - 1));
		b.healthy_flag = ($urandom_range(0, 99) < health_pct);
		case ($urandom_range(0, 3))
			0: b.connection_count = CONN_W'($urandom_range(0, 3));
			1: b.connection_count = '1;
			default: b.connection_count = CONN_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: b.latency_us = LAT_W'($urandom_range(0, 3));
			1: b.latency_us = '1;
			default: b.latency_us = LAT_W'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: b.client_hash = '0;
			1: b.client_hash = '1;
			default: b.client_hash = $urandom;
		endcase
		b.hash_present = ($urandom_range(0, 3) != 0);
		return b;
	endfunction

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		plan_row_t row;
		lb_req_t beat;
		lb_pick_t typed_pick;
		logic [WORD_W-1:0] cfg_word;
		int unsigned health_pct;

		// every block input known from time zero, reset held low
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_STRATEGY;
		cfg_data <= '0;
		req_bus.valid <= 1'b0;
		req_bus.opcode <= OP_UPDATE;
		req_bus.entry_index <= '0;
		req_bus.healthy_flag <= 1'b0;
		req_bus.connection_count <= '0;
		req_bus.latency_us <= '0;
		req_bus.client_hash <= '0;
		req_bus.hash_present <= 1'b0;
		clear_predictor();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan: register rows wait for an idle block first
		foreach (directed_plan[r]) begin
			row = directed_plan[r];
			case (row.kind)
				ROW_SET_STRATEGY: begin
					settle_block();
					write_reg(CFG_STRATEGY, row.word);
				end
				ROW_SET_SEED: begin
					settle_block();
					write_reg(CFG_SEED, row.word);
				end
				default: begin
					beat.opcode = row.opcode;
					beat.entry_index = row.entry_index;
					beat.healthy_flag = row.healthy_flag;
					beat.connection_count = row.connection_count;
					beat.latency_us = row.latency_us;
					beat.client_hash = row.word;
					beat.hash_present = row.hash_present;
					typed_pick.found = row.want_found;
					typed_pick.chosen_index = row.want_index;
					send_beat(beat, row.pinned, typed_pick);
				end
			endcase
		end

		// random phases: every strategy code once, then random ones, a fresh seed each
		for (int phase = 0; phase < PHASES; phase++) begin
			settle_block();
			cfg_word = $urandom;
			cfg_word[2:0] = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
			write_reg(CFG_STRATEGY, cfg_word);
			case (phase % 4)
				0: cfg_word = 32'd1;
				1: cfg_word = '1;
				2: cfg_word = '0;
				default: cfg_word = $urandom;
			endcase
			write_reg(CFG_SEED, cfg_word);
			// one phase in four runs back to back on both sides
			gaps_on = (phase % 4 != 1);
			health_pct = $urandom_range(10, 95);
			// mid-run the result side holds off while the sender keeps offering
			if (phase == 5) begin
				hold_pending = 1'b1;
			end
			for (int k = 0; k < BEATS_PER_PHASE; k++) begin
				send_beat(random_beat(health_pct), 1'b0, '0);
			end
		end

		settle_block();
		if (mismatches == 0 && picks_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// ---------------------------------------------------------------- result side

	// ready drops for a random stall before each beat; a pending hold-off is
	// counted out here, in cycles, before the next stall
	initial begin : result_sink
		int unsigned stall;
		resp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				resp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_pending = 1'b0;
			end
			stall = idle_draw();
			if (stall != 0) begin
				resp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			resp_bus.ready <= 1'b1;
			do @(posedge clk); while (!(resp_bus.valid && resp_bus.ready));
		end
	end

	// every accepted result beat against the oldest owed pick, field by field
	always @(posedge clk) begin : pick_check
		lb_pick_t got;
		lb_pick_t due;
		if (arst_n === 1'b1 && resp_bus.valid && resp_bus.ready) begin
			got.found = resp_bus.found;
			got.chosen_index = resp_bus.chosen_index;
			if (picks_due.size() == 0) begin
				report_mismatch("result beat with nothing owed", got, '0);
			end else begin
				due = picks_due.pop_front();
				if (got.found !== due.found) begin
					report_mismatch("found", got, due);
				end
				if (got.chosen_index !== due.chosen_index) begin
					report_mismatch("chosen_index", got, due);
				end
			end
		end
	end

	// overall limit, several times the slowest correct run
	initial begin : watchdog
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
